// ===== hdl/rmf_pkg.sv =====
// Shared types, sizing constants and compare helpers of the RGB 3x3 median filter.
// Used by rmf_front, rmf_median, rmf_back and the top level; depends on nothing.
`default_nettype none

package rmf_pkg;

    // Widest image line the line stores hold, and the tallest frame supported.
    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 2048;
    // Side of the square window.
    localparam int WIN          = 3;

    localparam int DIM_W  = 12;                       // configuration register width
    localparam int ADDR_W = $clog2(MAX_WIDTH);        // column / line store address
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);     // row position
    localparam int DIM_MIN = 3;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } t_kind;

    typedef enum logic {
        OP_PIXEL,
        OP_DRAIN
    } t_op;

    // Where the result value comes from.
    typedef enum logic [1:0] {
        SEL_CORNER,   // right-border pixel two lines back
        SEL_CENTER,   // window center, border pass-through
        SEL_MEDIAN,   // interior pixel, filtered
        SEL_LINE      // last line of the frame, read from the newer line store
    } t_sel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef logic [WIN-1:0][7:0] t_chan;

    typedef struct packed {
        t_rgb top;
        t_rgb mid;
        t_rgb bot;
    } t_column;

    // Index 0 is the oldest column.
    typedef t_column [WIN-1:0] t_window;

    typedef struct packed {
        t_op               op;
        t_sel              sel;
        logic              emit;
        logic              last;
        logic              capture;
        logic [ADDR_W-1:0] addr;
        t_rgb              pix;
    } t_cmd;

    typedef struct packed {
        t_rgb pix;
        logic last;
    } t_res;

    function automatic logic [ADDR_W-1:0] width_m1(input logic [DIM_W-1:0] v);
        int w;
        w = int'(v);
        if (w < DIM_MIN) w = DIM_MIN;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return ADDR_W'(w - 1);
    endfunction

    function automatic logic [ROW_W-1:0] height_m1(input logic [DIM_W-1:0] v);
        int h;
        h = int'(v);
        if (h < DIM_MIN) h = DIM_MIN;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        return ROW_W'(h - 1);
    endfunction

    localparam logic [ADDR_W-1:0] WIDTH_M1_RESET  = width_m1(WIDTH_RESET);
    localparam logic [ROW_W-1:0]  HEIGHT_M1_RESET = height_m1(HEIGHT_RESET);

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [7:0] med8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max8(min8(a, b), min8(max8(a, b), c));
    endfunction

    function automatic t_rgb rgb_min3(input t_rgb a, input t_rgb b, input t_rgb c);
        t_chan x, y, z, q;
        x = a;
        y = b;
        z = c;
        for (int k = 0; k < WIN; k++) q[k] = min8(min8(x[k], y[k]), z[k]);
        return q;
    endfunction

    function automatic t_rgb rgb_max3(input t_rgb a, input t_rgb b, input t_rgb c);
        t_chan x, y, z, q;
        x = a;
        y = b;
        z = c;
        for (int k = 0; k < WIN; k++) q[k] = max8(max8(x[k], y[k]), z[k]);
        return q;
    endfunction

    function automatic t_rgb rgb_med3(input t_rgb a, input t_rgb b, input t_rgb c);
        t_chan x, y, z, q;
        x = a;
        y = b;
        z = c;
        for (int k = 0; k < WIN; k++) q[k] = med8(x[k], y[k], z[k]);
        return q;
    endfunction

    // Sorts each channel of a column: top gets the smallest, bot the largest.
    function automatic t_column sort_column(input t_column c);
        t_column s;
        s.top = rgb_min3(c.top, c.mid, c.bot);
        s.mid = rgb_med3(c.top, c.mid, c.bot);
        s.bot = rgb_max3(c.top, c.mid, c.bot);
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rmf_front.sv =====
// Front end of the median filter: configuration, raster position tracking,
// item classification and the command queue. Depends on rmf_pkg.
`default_nettype none

module rmf_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [rmf_pkg::DIM_W-1:0] i_cfg_data,
    input  wire logic                      i_push,
    output      logic                      o_full,
    input  wire logic                      i_kind,
    input  wire rmf_pkg::t_rgb             i_pix,
    output      logic                      o_cmd_vld,
    output      rmf_pkg::t_cmd             o_cmd,
    input  wire logic                      i_cmd_pop
);

    localparam logic [rmf_pkg::ADDR_W-1:0]     ONE_A   = rmf_pkg::ADDR_W'(1);
    localparam logic [rmf_pkg::ROW_W-1:0]      ONE_R   = rmf_pkg::ROW_W'(1);
    localparam logic [rmf_pkg::ROW_W:0]        ONE_RR  = (rmf_pkg::ROW_W + 1)'(1);
    localparam logic [rmf_pkg::CMDQ_PTR_W-1:0] PTR_END =
        rmf_pkg::CMDQ_PTR_W'(rmf_pkg::CMDQ_DEPTH - 1);

    logic [rmf_pkg::ADDR_W-1:0] r_w_m1;
    logic [rmf_pkg::ROW_W-1:0]  r_h_m1;
    logic [rmf_pkg::ADDR_W-1:0] r_col, n_col;
    logic [rmf_pkg::ROW_W-1:0]  r_row, n_row;
    logic [rmf_pkg::ADDR_W-1:0] r_res_col, n_res_col;
    logic [rmf_pkg::ROW_W:0]    r_res_row, n_res_row;
    logic                       r_done, n_done;

    rmf_pkg::t_cmd                  r_q [rmf_pkg::CMDQ_DEPTH];
    logic [rmf_pkg::CMDQ_PTR_W-1:0] r_wp, r_rp;
    logic [rmf_pkg::CMDQ_CNT_W-1:0] r_cnt;

    logic                       accept;
    logic                       cmd_push;
    rmf_pkg::t_cmd              cmd;
    logic [rmf_pkg::ADDR_W-1:0] col;
    logic [rmf_pkg::ROW_W-1:0]  row;
    logic [rmf_pkg::ADDR_W-1:0] res_col;
    logic [rmf_pkg::ROW_W:0]    res_row;
    logic [rmf_pkg::ROW_W:0]    h_m1_x;
    logic                       is_pixel;
    logic                       col_end, row_end, res_col_end, res_row_last;

    // A configuration write takes the cycle; no item is taken alongside it.
    assign o_full = (r_cnt == rmf_pkg::CMDQ_CNT_W'(rmf_pkg::CMDQ_DEPTH)) || i_cfg_we;
    assign accept = i_push && !o_full;
    assign h_m1_x = {1'b0, r_h_m1};

    always_comb begin
        is_pixel = (i_kind == rmf_pkg::KIND_PIXEL);
        // A pixel after a complete frame opens a new frame.
        col     = r_done ? '0 : r_col;
        row     = r_done ? '0 : r_row;
        res_col = (is_pixel && r_done) ? '0 : r_res_col;
        res_row = (is_pixel && r_done) ? '0 : r_res_row;

        col_end      = (col == r_w_m1);
        row_end      = (row == r_h_m1);
        res_col_end  = (res_col == r_w_m1);
        res_row_last = (res_row == h_m1_x);

        n_col     = r_col;
        n_row     = r_row;
        n_res_col = r_res_col;
        n_res_row = r_res_row;
        n_done    = r_done;
        cmd_push  = 1'b0;

        cmd         = '0;
        cmd.op      = rmf_pkg::OP_PIXEL;
        cmd.sel     = rmf_pkg::SEL_CENTER;
        cmd.pix     = i_pix;
        cmd.last    = res_row_last && res_col_end;
        cmd.capture = col_end;

        if (i_cfg_we) begin
            n_col     = '0;
            n_row     = '0;
            n_res_col = '0;
            n_res_row = '0;
            n_done    = 1'b0;
        end else if (accept) begin
            if (is_pixel) begin
                cmd_push = 1'b1;
                cmd.addr = col;
                cmd.emit = (row > ONE_R) || ((row == ONE_R) && (col != '0));
                if (col == '0) begin
                    cmd.sel = rmf_pkg::SEL_CORNER;
                end else if ((res_row == '0) || res_row_last ||
                             (res_col == '0) || res_col_end) begin
                    cmd.sel = rmf_pkg::SEL_CENTER;
                end else begin
                    cmd.sel = rmf_pkg::SEL_MEDIAN;
                end
                n_done    = 1'b0;
                n_row     = row;
                n_res_col = res_col;
                n_res_row = res_row;
                if (col_end) begin
                    n_col = '0;
                    if (row_end) begin
                        n_row  = '0;
                        n_done = 1'b1;
                    end else begin
                        n_row = row + ONE_R;
                    end
                end else begin
                    n_col = col + ONE_A;
                end
            end else if (r_done && (r_res_row <= h_m1_x)) begin
                cmd_push = 1'b1;
                cmd.op   = rmf_pkg::OP_DRAIN;
                cmd.emit = 1'b1;
                cmd.addr = res_col;
                cmd.sel  = (res_row == (h_m1_x - ONE_RR)) ? rmf_pkg::SEL_CORNER
                                                          : rmf_pkg::SEL_LINE;
            end
            if (cmd_push && cmd.emit) begin
                if (res_col_end) begin
                    n_res_col = '0;
                    n_res_row = res_row + ONE_RR;
                end else begin
                    n_res_col = res_col + ONE_A;
                    n_res_row = res_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1    <= rmf_pkg::WIDTH_M1_RESET;
            r_h_m1    <= rmf_pkg::HEIGHT_M1_RESET;
            r_col     <= '0;
            r_row     <= '0;
            r_res_col <= '0;
            r_res_row <= '0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (rmf_pkg::t_reg_idx'(i_cfg_idx))
                    rmf_pkg::REG_WIDTH:  r_w_m1 <= rmf_pkg::width_m1(i_cfg_data);
                    rmf_pkg::REG_HEIGHT: r_h_m1 <= rmf_pkg::height_m1(i_cfg_data);
                    default: ;
                endcase
            end
            r_col     <= n_col;
            r_row     <= n_row;
            r_res_col <= n_res_col;
            r_res_row <= n_res_row;
            r_done    <= n_done;
        end
    end

    // Command queue toward the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (cmd_push) r_wp <= (r_wp == PTR_END) ? '0 : r_wp + 1'b1;
            if (i_cmd_pop) r_rp <= (r_rp == PTR_END) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + rmf_pkg::CMDQ_CNT_W'(cmd_push)
                           - rmf_pkg::CMDQ_CNT_W'(i_cmd_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_push) r_q[r_wp] <= cmd;
    end

    assign o_cmd_vld = (r_cnt != '0);
    assign o_cmd     = r_q[r_rp];

endmodule

`default_nettype wire

// ===== hdl/rmf_median.sv =====
// Two-stage median-of-nine network for three channels, with result selection.
// Sorts columns, then reduces; depends on rmf_pkg.
`default_nettype none

module rmf_median (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_vld,
    input  wire logic             i_use_med,
    input  wire logic             i_last,
    input  wire rmf_pkg::t_rgb    i_val,
    input  wire rmf_pkg::t_window i_win,
    output      logic             o_vld,
    output      rmf_pkg::t_res    o_res
);

    rmf_pkg::t_window n_sorted, r_sorted;
    logic             r_a_vld, r_a_med, r_a_last;
    rmf_pkg::t_rgb    r_a_val;

    logic             r_b_vld, r_b_med, r_b_last;
    rmf_pkg::t_rgb    r_b_val, r_b_lmax, r_b_mmed, r_b_hmin;

    // Stage A: sort every column of the window.
    always_comb begin
        for (int k = 0; k < rmf_pkg::WIN; k++) n_sorted[k] = rmf_pkg::sort_column(i_win[k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sorted <= n_sorted;
        r_a_med  <= i_use_med;
        r_a_last <= i_last;
        r_a_val  <= i_val;

        // Stage B: largest of the minima, median of medians, smallest of maxima.
        r_b_lmax <= rmf_pkg::rgb_max3(r_sorted[0].top, r_sorted[1].top, r_sorted[2].top);
        r_b_mmed <= rmf_pkg::rgb_med3(r_sorted[0].mid, r_sorted[1].mid, r_sorted[2].mid);
        r_b_hmin <= rmf_pkg::rgb_min3(r_sorted[0].bot, r_sorted[1].bot, r_sorted[2].bot);
        r_b_med  <= r_a_med;
        r_b_last <= r_a_last;
        r_b_val  <= r_a_val;
    end

    // The median of those three is the median of all nine.
    assign o_vld      = r_b_vld;
    assign o_res.pix  = r_b_med ? rmf_pkg::rgb_med3(r_b_lmax, r_b_mmed, r_b_hmin) : r_b_val;
    assign o_res.last = r_b_last;

endmodule

`default_nettype wire

// ===== hdl/rmf_back.sv =====
// Back end of the median filter: line stores, window, median pipeline and result queue.
// Depends on rmf_pkg and rmf_median.
`default_nettype none

module rmf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_vld,
    input  wire rmf_pkg::t_cmd i_cmd,
    output      logic          o_cmd_pop,
    output      logic          o_res_vld,
    output      rmf_pkg::t_res o_res,
    input  wire logic          i_res_pop
);

    localparam logic [rmf_pkg::OUTQ_PTR_W-1:0] PTR_END =
        rmf_pkg::OUTQ_PTR_W'(rmf_pkg::OUTQ_DEPTH - 1);
    localparam logic [rmf_pkg::OUTQ_CNT_W-1:0] OUTQ_FULL =
        rmf_pkg::OUTQ_CNT_W'(rmf_pkg::OUTQ_DEPTH);

    rmf_pkg::t_rgb r_older_mem [rmf_pkg::MAX_WIDTH];
    rmf_pkg::t_rgb r_newer_mem [rmf_pkg::MAX_WIDTH];
    rmf_pkg::t_rgb r_older_rd, r_newer_rd;

    logic [rmf_pkg::OUTQ_CNT_W-1:0] r_credit;
    logic                           r_s1_vld;
    rmf_pkg::t_cmd                  r_s1_cmd;
    rmf_pkg::t_window               r_win;
    rmf_pkg::t_rgb                  r_corner;

    logic          r_s2_vld, r_s2_med, r_s2_last;
    rmf_pkg::t_rgb r_s2_val;

    rmf_pkg::t_res                  r_oq [rmf_pkg::OUTQ_DEPTH];
    logic [rmf_pkg::OUTQ_PTR_W-1:0] r_wp, r_rp;
    logic [rmf_pkg::OUTQ_CNT_W-1:0] r_cnt;

    logic          shift;
    logic          res_pop;
    logic          med_vld;
    rmf_pkg::t_res med_res;
    rmf_pkg::t_rgb val;

    // A command that yields a result leaves only with a reserved result slot,
    // so the pipeline behind it never has to stall.
    assign o_cmd_pop = i_cmd_vld && (!i_cmd.emit || (r_credit < OUTQ_FULL));
    assign res_pop   = i_res_pop && o_res_vld;
    assign shift     = r_s1_vld && (r_s1_cmd.op == rmf_pkg::OP_PIXEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + rmf_pkg::OUTQ_CNT_W'(o_cmd_pop && i_cmd.emit)
                                 - rmf_pkg::OUTQ_CNT_W'(res_pop);
        end
    end

    // Line stores: read at the popped command's column, written in the cycle after.
    always_ff @(posedge i_clk) begin
        if (shift) r_older_mem[r_s1_cmd.addr] <= r_newer_rd;
        r_older_rd <= r_older_mem[i_cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (shift) r_newer_mem[r_s1_cmd.addr] <= r_s1_cmd.pix;
        r_newer_rd <= r_newer_mem[i_cmd.addr];
    end

    always_comb begin
        case (r_s1_cmd.sel)
            rmf_pkg::SEL_CORNER: val = r_corner;
            rmf_pkg::SEL_LINE:   val = r_newer_rd;
            default:             val = r_win[2].mid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= o_cmd_pop;
            r_s2_vld <= r_s1_vld && r_s1_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_s1_cmd <= i_cmd;
        if (shift) begin
            for (int k = 0; k < rmf_pkg::WIN - 1; k++) r_win[k] <= r_win[k + 1];
            r_win[rmf_pkg::WIN - 1] <= '{top: r_older_rd, mid: r_newer_rd, bot: r_s1_cmd.pix};
            // The right-border pixel of the previous line, needed at the next line start.
            if (r_s1_cmd.capture) r_corner <= r_newer_rd;
        end
        r_s2_med  <= (r_s1_cmd.sel == rmf_pkg::SEL_MEDIAN);
        r_s2_last <= r_s1_cmd.last;
        r_s2_val  <= val;
    end

    rmf_median u_median (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r_s2_vld),
        .i_use_med (r_s2_med),
        .i_last    (r_s2_last),
        .i_val     (r_s2_val),
        .i_win     (r_win),
        .o_vld     (med_vld),
        .o_res     (med_res)
    );

    // Result queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (med_vld) r_wp <= (r_wp == PTR_END) ? '0 : r_wp + 1'b1;
            if (res_pop) r_rp <= (r_rp == PTR_END) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + rmf_pkg::OUTQ_CNT_W'(med_vld) - rmf_pkg::OUTQ_CNT_W'(res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (med_vld) r_oq[r_wp] <= med_res;
    end

    assign o_res_vld = (r_cnt != '0);
    assign o_res     = r_oq[r_rp];

endmodule

`default_nettype wire

// ===== hdl/rgb_median_filter_3x3.sv =====
// Streaming 3x3 median filter for RGB pixels, one pixel per clock sustained while
// full is low, set by the single read port of each line store. A result passes the
// command queue, the back-end stages, the median stages and the result queue;
// the stream itself lags one image line plus one pixel behind.
// Reset (synchronous, active low) clears queues, positions and sets 640 x 480;
// line stores, window and data registers keep their contents.
`default_nettype none

module rgb_median_filter_3x3 (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Input queue side: a transfer happens when push is high and full is low.
    input  wire logic                      push,
    output      logic                      full,
    input  wire logic                      i_kind,
    input  wire logic [7:0]                i_red_in,
    input  wire logic [7:0]                i_green_in,
    input  wire logic [7:0]                i_blue_in,
    // Result queue side: a transfer happens when pop is high and empty is low.
    output      logic                      empty,
    input  wire logic                      pop,
    output      logic [7:0]                o_red_out,
    output      logic [7:0]                o_green_out,
    output      logic [7:0]                o_blue_out,
    output      logic                      o_frame_last,
    // Configuration write port: index 0 is the image width, index 1 the height.
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [rmf_pkg::DIM_W-1:0] i_cfg_data
);

    rmf_pkg::t_rgb w_pix;
    logic          w_cmd_vld;
    rmf_pkg::t_cmd w_cmd;
    logic          w_cmd_pop;
    logic          w_res_vld;
    rmf_pkg::t_res w_res;

    assign w_pix = '{red: i_red_in, green: i_green_in, blue: i_blue_in};

    // The front end tracks the raster position of the next pixel and of the next
    // result, decides for every item whether and how it yields a result, and queues
    // a command. Drain items after a frame only become commands while results of
    // that frame are still owed.
    rmf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .o_full     (full),
        .i_kind     (i_kind),
        .i_pix      (w_pix),
        .o_cmd_vld  (w_cmd_vld),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    // The back end reads both line stores, shifts the window, runs the median
    // network and queues results. It takes a command that yields a result only when a
    // result slot is free, so a stalled consumer holds commands in the front queue instead.
    rmf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (w_cmd_vld),
        .i_cmd     (w_cmd),
        .o_cmd_pop (w_cmd_pop),
        .o_res_vld (w_res_vld),
        .o_res     (w_res),
        .i_res_pop (pop)
    );

    assign empty        = !w_res_vld;
    assign o_red_out    = w_res.pix.red;
    assign o_green_out  = w_res.pix.green;
    assign o_blue_out   = w_res.pix.blue;
    assign o_frame_last = w_res.last;

    // The back end never takes a command that is not there.
    a_pop_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_vld)
        else $error("command taken from an empty command queue");

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result waiting right after reset");

    // A command that yields a result reaches the result queue after the fixed pipeline.
    a_result_arrives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_pop && w_cmd.emit) |-> ##5 !empty)
        else $error("result of a taken command did not arrive in time");

endmodule

`default_nettype wire

// ===== verif/rgb_median_filter_3x3_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streaming RGB 3x3 median filter.
// Depends on rmf_pkg and rgb_median_filter_3x3; an internal predictor
// supplies the expected pixels.

module rgb_median_filter_3x3_tb;

    import rmf_pkg::*;

    // A correct run is about 2.1k items. Allowing the longest sender gap, the longest
    // receiver stall, the pipeline and the quiet waits for every item, the limit is
    // still several times what such a run needs.
    localparam int unsigned CYCLE_LIMIT   = 400_000;
    // Enough cycles for an item that causes no result to leave the pipeline.
    localparam int unsigned QUIET_CYCLES  = 20;
    localparam int unsigned RANDOM_ITEMS  = 1820;
    localparam int unsigned CALM_FROM     = 1550;
    localparam int unsigned PRINT_LIMIT   = 50;

    // Hand-picked pixels for the first 3x3 frames: channel extremes, ties and
    // a center whose median differs from every neighbour.
    localparam logic [8:0][23:0] DIRECTED_PIX = {
        24'h0180FE, 24'h000000, 24'hFFFFFF, 24'h7F7F7F, 24'h808080,
        24'hFF00FF, 24'h00FF00, 24'hFFFFFF, 24'h000000
    };

    typedef struct packed {
        t_kind      kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } filt_t;

    // All inputs of the block start at known values.
    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              push         = 1'b0;
    logic              full;
    logic              i_kind       = KIND_PIXEL;
    logic [7:0]        i_red_in     = '0;
    logic [7:0]        i_green_in   = '0;
    logic [7:0]        i_blue_in    = '0;
    logic              empty;
    logic              pop          = 1'b0;
    logic [7:0]        o_red_out;
    logic [7:0]        o_green_out;
    logic [7:0]        o_blue_out;
    logic              o_frame_last;
    logic              i_cfg_we     = 1'b0;
    logic              i_cfg_idx    = REG_WIDTH;
    logic [DIM_W-1:0]  i_cfg_data   = '0;

    rgb_median_filter_3x3 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .empty        (empty),
        .pop          (pop),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_last (o_frame_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Stimulus waiting to be sent and filtered pixels waiting to come out.
    pix_item_t   pixel_feed[$];
    filt_t       filtered_q[$];

    pix_item_t   feed_item;
    bit          feed_busy;        // an item sits on the input ports
    int unsigned feed_gap;
    int unsigned out_stall;
    bit          calm;             // no idling on either side in the last part
    int unsigned queued_items;
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned cycle_count;

    // Predictor state: register copies, line stores, window and positions.
    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    logic [23:0]      older_line [MAX_WIDTH];
    logic [23:0]      newer_line [MAX_WIDTH];
    logic [8:0][23:0] win_cells;   // three columns of top, mid, bottom; 0 is oldest
    int unsigned      in_col;
    int unsigned      in_row;
    int unsigned      out_col;
    int unsigned      out_row;
    bit               frame_done;

    // Width and height as the block uses them: out-of-range values are clamped.
    function automatic int unsigned dim_used(input logic [DIM_W-1:0] v,
                                             input int unsigned top);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > top) return top;
        return v;
    endfunction

    // Fifth smallest of the nine window values of one channel.
    function automatic logic [7:0] chan_median(input logic [8:0][23:0] cells,
                                               input int unsigned sh);
        logic [7:0] v [9];
        logic [7:0] t;
        for (int i = 0; i < 9; i++) v[i] = cells[i][sh +: 8];
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8 - i; j++) begin
                if (v[j] > v[j + 1]) begin
                    t        = v[j];
                    v[j]     = v[j + 1];
                    v[j + 1] = t;
                end
            end
        end
        return v[4];
    endfunction

    task automatic restart_frame();
        in_col     = 0;
        in_row     = 0;
        out_col    = 0;
        out_row    = 0;
        frame_done = 1'b0;
    endtask

    // Records one filtered pixel and advances the output position. The last
    // pixel of the frame is the one at the bottom-right corner.
    task automatic queue_filtered(input logic [23:0] val, input int unsigned w,
                                  input int unsigned h);
        filt_t f;
        f.red   = val[23:16];
        f.green = val[15:8];
        f.blue  = val[7:0];
        f.last  = (out_row == h - 1) && (out_col == w - 1);
        filtered_q.push_back(f);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
    endtask

    // Works out what one accepted item does to the stream.
    task automatic filter_step(input bit drain, input logic [23:0] pix);
        int unsigned w, h, x, y;
        logic [23:0] top, mid, val;
        w = dim_used(cfg_width, MAX_WIDTH);
        h = dim_used(cfg_height, HEIGHT_LIMIT);
        if (drain) begin
            // A drain only counts once the whole frame is in and while
            // results of that frame are still owed.
            if (!frame_done || out_row >= h) return;
            // The first owed pixel is the right border of the line before
            // last, which has moved on to the older store.
            if (out_row == h - 2) val = older_line[w - 1];
            else val = newer_line[out_col];
            queue_filtered(val, w, h);
            return;
        end
        // A pixel after a complete frame opens the next one and drops
        // whatever was not drained.
        if (frame_done) restart_frame();
        x   = in_col;
        y   = in_row;
        top = older_line[x];
        mid = newer_line[x];
        for (int i = 0; i < 6; i++) win_cells[i] = win_cells[i + 3];
        win_cells[6] = top;
        win_cells[7] = mid;
        win_cells[8] = pix;
        older_line[x] = mid;
        newer_line[x] = pix;
        if (y >= 2 || (y == 1 && x >= 1)) begin
            if (x == 0) begin
                // Right border pixel of two lines back.
                val = older_line[w - 1];
            end else if (out_row == 0 || out_row == h - 1 ||
                         out_col == 0 || out_col == w - 1) begin
                val = win_cells[4];
            end else begin
                val = {chan_median(win_cells, 16), chan_median(win_cells, 8),
                       chan_median(win_cells, 0)};
            end
            queue_filtered(val, w, h);
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) begin
                in_row     = 0;
                frame_done = 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("ERROR: result %0d %s: got %0h, expected %0h",
                     results_seen, what, got, want);
    endtask

    // Driver: keeps an item on the input ports until its transfer, with
    // random gaps between items except in the last part of the run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                filter_step(feed_item.kind == KIND_DRAIN,
                            {feed_item.red, feed_item.green, feed_item.blue});
                feed_busy = 1'b0;
            end
            if (!push || !full) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                    push <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    feed_gap = $urandom_range(1, 10) - 1;
                    push <= 1'b0;
                end else if (pixel_feed.size() > 0) begin
                    feed_item = pixel_feed.pop_front();
                    feed_busy = 1'b1;
                    push       <= 1'b1;
                    i_kind     <= feed_item.kind;
                    i_red_in   <= feed_item.red;
                    i_green_in <= feed_item.green;
                    i_blue_in  <= feed_item.blue;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares every transfer on the result side with the oldest
    // expected pixel, and stalls in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch("with nothing expected",
                                    {o_red_out, o_green_out, o_blue_out}, 0);
                end else begin
                    filt_t want;
                    want = filtered_q.pop_front();
                    if (o_red_out !== want.red)
                        report_mismatch("red", o_red_out, want.red);
                    if (o_green_out !== want.green)
                        report_mismatch("green", o_green_out, want.green);
                    if (o_blue_out !== want.blue)
                        report_mismatch("blue", o_blue_out, want.blue);
                    if (o_frame_last !== want.last)
                        report_mismatch("frame_last", o_frame_last, want.last);
                end
                results_seen++;
            end
            if (out_stall > 0) begin
                out_stall--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall = $urandom_range(1, 10) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: a run that hangs is a failed run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("rgb_median_filter_3x3 verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] rand_chan();
        // Frequent extremes and repeats make ties in the median.
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_pixel(input logic [23:0] rgb);
        pix_item_t it;
        it.kind  = KIND_PIXEL;
        it.red   = rgb[23:16];
        it.green = rgb[15:8];
        it.blue  = rgb[7:0];
        pixel_feed.push_back(it);
    endtask

    // Drain ticks carry random channel values, which the block must ignore.
    task automatic add_drain();
        pix_item_t it;
        it.kind  = KIND_DRAIN;
        it.red   = 8'($urandom);
        it.green = 8'($urandom);
        it.blue  = 8'($urandom);
        pixel_feed.push_back(it);
    endtask

    // Queues npix random pixels, with the odd stray drain tick mid-frame,
    // then ndrain drain ticks.
    task automatic queue_frame(input int unsigned npix, input int unsigned ndrain);
        for (int unsigned i = 0; i < npix; i++) begin
            if ($urandom_range(0, 29) == 0) add_drain();
            add_pixel({rand_chan(), rand_chan(), rand_chan()});
        end
        repeat (ndrain) add_drain();
    endtask

    // Waits until everything sent has been transferred and every expected
    // pixel has come out, then lets the pipeline run empty.
    task automatic wait_quiet();
        while (pixel_feed.size() != 0 || feed_busy || filtered_q.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register; the block restarts its frame, and so does the predictor.
    task automatic write_cfg(input t_reg_idx idx, input logic [DIM_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WIDTH) cfg_width = value;
        else cfg_height = value;
        restart_frame();
    endtask

    // One random phase: a new image size, then a few frames. Most frames are
    // complete and fully drained; some are drained only in part, so the next
    // frame drops the rest, and the odd one is cut short before the next write.
    task automatic random_phase();
        logic [DIM_W-1:0] wr, hr;
        int unsigned w, h, frames, npix, ndrain, pick;
        wr = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 2))
                                         : DIM_W'($urandom_range(3, 12));
        hr = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 2))
                                         : DIM_W'($urandom_range(3, 8));
        wait_quiet();
        case ($urandom_range(0, 3))
            0:       write_cfg(REG_WIDTH, wr);
            1:       write_cfg(REG_HEIGHT, hr);
            default: begin
                write_cfg(REG_WIDTH, wr);
                write_cfg(REG_HEIGHT, hr);
            end
        endcase
        w      = dim_used(cfg_width, MAX_WIDTH);
        h      = dim_used(cfg_height, HEIGHT_LIMIT);
        frames = $urandom_range(1, 3);
        for (int unsigned f = 0; f < frames; f++) begin
            pick = $urandom_range(0, 9);
            npix = w * h;
            if (pick < 7) begin
                ndrain = w + 1 + $urandom_range(0, 2);
            end else if (pick < 9 || f + 1 < frames) begin
                ndrain = $urandom_range(0, w);
            end else begin
                npix   = $urandom_range(1, w * h - 1);
                ndrain = $urandom_range(0, 2);
            end
            queue_frame(npix, ndrain);
            queued_items += npix + ((ndrain < w + 1) ? ndrain : w + 1);
        end
    endtask

    initial begin
        // Predictor starts from the reset state of the block.
        cfg_width  = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        win_cells = '0;
        restart_frame();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A few pixels at the reset size of 640 x 480, and a drain tick in the
        // middle of that frame: none of them gives a result.
        add_pixel(24'hFFFFFF);
        add_drain();
        add_pixel(24'h000000);
        wait_quiet();

        // Smallest image. The first frame has a stray drain tick mid-frame,
        // then is drained in full, plus one tick more that must be ignored.
        write_cfg(REG_WIDTH, DIM_W'(3));
        write_cfg(REG_HEIGHT, DIM_W'(3));
        for (int i = 0; i < 9; i++) begin
            if (i == 4) add_drain();
            add_pixel(DIRECTED_PIX[i]);
        end
        repeat (5) add_drain();
        // The second frame gets a single drain tick; the next frame drops the rest.
        for (int i = 0; i < 9; i++) add_pixel(~DIRECTED_PIX[8 - i]);
        add_drain();
        queue_frame(9, 4);

        // Widest line: 4095 is clamped to 2048, height 0 is clamped to 3. Part of
        // the first line goes in, and the unfinished frame ignores the drain tick.
        wait_quiet();
        write_cfg(REG_WIDTH, DIM_W'(4095));
        write_cfg(REG_HEIGHT, DIM_W'(0));
        queue_frame(40, 1);

        // Tall frame: width 2 is clamped to 3, height 4095 to 2048. Twelve lines
        // go in; the frame is far from complete, so its drain ticks are ignored.
        wait_quiet();
        write_cfg(REG_WIDTH, DIM_W'(2));
        write_cfg(REG_HEIGHT, DIM_W'(4095));
        queue_frame(3 * 12, 5);

        // Random phases; the sender waits for every expected pixel between
        // phases. The last stretch runs without idling on either side.
        while (queued_items < RANDOM_ITEMS) begin
            if (queued_items >= CALM_FROM) begin
                wait_quiet();
                calm = 1'b1;
            end
            random_phase();
        end

        wait_quiet();
        if (mismatches == 0) begin
            $display("rgb_median_filter_3x3 verification clean");
        end else begin
            $display("rgb_median_filter_3x3 verification failed");
        end
        $finish;
    end

endmodule
